>>> sv/pfe_pkg.sv
// ============================================================================
// pfe_pkg: shared types and constants of the postfix expression evaluator
// Holds the command record passed from the front to the back, the operation
// codes, the status codes and the character codes that the front decodes.
// ============================================================================
`default_nettype none

package pfe_pkg;

  // data path width of stack values
  localparam int DATA_W = 32;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // character codes
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // decoded operation
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_DIGIT = 3'd1,
    OP_ADD   = 3'd2,
    OP_SUB   = 3'd3,
    OP_MUL   = 3'd4,
    OP_DIV   = 3'd5
  } op_t;

  // result status
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_DIVZERO   = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  // one command in the queue
  typedef struct packed {
    op_t        op;
    logic [3:0] digit;
    logic       last;
  } cmd_t;

endpackage

`default_nettype wire

>>> sv/pfe_front.sv
// ============================================================================
// pfe_front: character decoder
// Accepts one character per request, classifies it as digit, operator or
// ignored, and forwards the commands that matter to the command queue.
// ============================================================================
`default_nettype none

module pfe_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [7:0]    char_code,
  input  wire logic          is_last,
  input  wire logic          push,
  output logic               full,
  output logic               q_push,
  output pfe_pkg::cmd_t      q_cmd,
  input  wire logic          q_full
);

  pfe_pkg::cmd_t cmd_c;
  pfe_pkg::cmd_t hold_cmd;
  logic          hold_valid;
  logic          keep;
  logic          accept;
  logic          move;

  // classify the incoming character
  always_comb begin
    cmd_c.op    = pfe_pkg::OP_NONE;
    cmd_c.digit = 4'd0;
    cmd_c.last  = is_last;
    priority if (char_code >= pfe_pkg::CH_0 && char_code <= pfe_pkg::CH_9) begin
      cmd_c.op    = pfe_pkg::OP_DIGIT;
      cmd_c.digit = 4'(char_code - pfe_pkg::CH_0);
    end else if (char_code == pfe_pkg::CH_PLUS) begin
      cmd_c.op = pfe_pkg::OP_ADD;
    end else if (char_code == pfe_pkg::CH_MINUS) begin
      cmd_c.op = pfe_pkg::OP_SUB;
    end else if (char_code == pfe_pkg::CH_STAR) begin
      cmd_c.op = pfe_pkg::OP_MUL;
    end else if (char_code == pfe_pkg::CH_SLASH) begin
      cmd_c.op = pfe_pkg::OP_DIV;
    end else begin
      cmd_c.op = pfe_pkg::OP_NONE;
    end
  end

  // ignored characters are dropped unless they close the expression
  assign keep   = (cmd_c.op != pfe_pkg::OP_NONE) || is_last;
  assign move   = hold_valid && !q_full;
  assign full   = hold_valid && q_full;
  assign accept = push && !full;
  assign q_push = move;
  assign q_cmd  = hold_cmd;

  // holding register in front of the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= keep;
    end else if (move) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      hold_cmd <= cmd_c;
    end
  end

endmodule

`default_nettype wire

>>> sv/pfe_queue.sv
// ============================================================================
// pfe_queue: command queue
// Small first-in first-out buffer that decouples the decoder from the
// stack engine so that each side can stall on its own.
// ============================================================================
`default_nettype none

module pfe_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire pfe_pkg::cmd_t wr_cmd,
  output logic               q_full,
  input  wire logic          rd_en,
  output pfe_pkg::cmd_t      rd_cmd,
  output logic               q_empty
);

  pfe_pkg::cmd_t                store [pfe_pkg::QUEUE_DEPTH];
  logic [pfe_pkg::QPTR_W-1:0]   wr_ptr;
  logic [pfe_pkg::QPTR_W-1:0]   rd_ptr;
  logic [pfe_pkg::QPTR_W:0]     fill;
  logic                         do_wr;
  logic                         do_rd;

  assign q_full  = (fill == (pfe_pkg::QPTR_W+1)'(pfe_pkg::QUEUE_DEPTH));
  assign q_empty = (fill == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_cmd  = store[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_cmd;
    end
  end

endmodule

`default_nettype wire

>>> sv/pfe_div.sv
// ============================================================================
// pfe_div: signed divider
// Restoring divider on magnitudes, one quotient bit per cycle, with the
// quotient sign fixed at the end; truncates toward zero and wraps.
// ============================================================================
`default_nettype none

module pfe_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [pfe_pkg::DATA_W-1:0] dividend,
  input  wire logic [pfe_pkg::DATA_W-1:0] divisor,
  output logic                            done,
  output logic [pfe_pkg::DATA_W-1:0]      quotient
);

  localparam int W   = pfe_pkg::DATA_W;
  localparam int SW  = $clog2(W);

  logic          busy;
  logic [SW-1:0] step;
  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  dvs;
  logic          neg;
  logic [W-1:0]  mag_a;
  logic [W-1:0]  mag_b;
  logic [W:0]    shifted;
  logic [W:0]    diff;

  // operand magnitudes
  assign mag_a = dividend[W-1] ? (W)'(0) - dividend : dividend;
  assign mag_b = divisor[W-1]  ? (W)'(0) - divisor  : divisor;

  // one restoring step
  assign shifted  = {rem, quo[W-1]};
  assign diff     = shifted - {1'b0, dvs};
  assign quotient = neg ? (W)'(0) - quo : quo;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == SW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // data path
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= mag_a;
      dvs <= mag_b;
      neg <= dividend[W-1] ^ divisor[W-1];
    end else if (busy) begin
      if (!diff[W]) begin
        rem <= diff[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= shifted[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/pfe_back.sv
// ============================================================================
// pfe_back: stack engine
// Executes queued commands on a value stack whose top lives in a register
// and the rest in a memory, and delivers the result of each expression.
// ============================================================================
`default_nettype none

module pfe_back #(
  parameter int STACK_DEPTH = 128
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       q_empty,
  input  wire pfe_pkg::cmd_t              q_cmd,
  output logic                            q_pop,
  output logic                            empty,
  input  wire logic                       pop,
  output logic [pfe_pkg::DATA_W-1:0]      result_value,
  output logic [1:0]                      status
);

  localparam int W  = pfe_pkg::DATA_W;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_DIV   = 4'b0100,
    S_FINAL = 4'b1000
  } state_t;

  state_t            state;
  state_t            after;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_m1;
  logic [CW-1:0]     count_m2;
  logic [W-1:0]      top;
  pfe_pkg::status_t  err;
  pfe_pkg::op_t      cur_op;
  logic              cur_last;
  logic              out_valid;
  logic [W-1:0]      mem [STACK_DEPTH];
  logic [W-1:0]      rd_data;
  logic              mem_we;
  logic              stack_full;
  logic              take;
  logic              div_start;
  logic              div_done;
  logic [W-1:0]      div_q;
  logic [W-1:0]      prod;
  logic              load_out;

  assign count_m1   = count - CW'(1);
  assign count_m2   = count - CW'(2);
  assign stack_full = (count == CW'(STACK_DEPTH));
  assign take       = (state == S_IDLE) && !q_empty;
  assign q_pop      = take;
  assign after      = cur_last ? S_FINAL : S_IDLE;
  assign empty      = !out_valid;
  assign load_out   = (state == S_FINAL) && (!out_valid || pop);
  assign prod       = rd_data * top;

  // spill the old top below a new digit
  assign mem_we = take && (err == pfe_pkg::ST_OK) && (q_cmd.op == pfe_pkg::OP_DIGIT)
                  && !stack_full && (count != '0);

  // stack memory, second operand registered from the entry below the top
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_m1[AW-1:0]] <= top;
    end
    rd_data <= mem[count_m2[AW-1:0]];
  end

  // divider
  assign div_start = (state == S_READ) && (cur_op == pfe_pkg::OP_DIV) && (top != '0);

  pfe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rd_data),
    .divisor  (top),
    .done     (div_done),
    .quotient (div_q)
  );

  // command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      err       <= pfe_pkg::ST_OK;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur_op   <= q_cmd.op;
            cur_last <= q_cmd.last;
            state    <= q_cmd.last ? S_FINAL : S_IDLE;
            if (err == pfe_pkg::ST_OK) begin
              unique case (q_cmd.op)
                pfe_pkg::OP_DIGIT: begin
                  if (stack_full) begin
                    err <= pfe_pkg::ST_OVERFLOW;
                  end else begin
                    top   <= {{(W-4){1'b0}}, q_cmd.digit};
                    count <= count + 1'b1;
                  end
                end
                pfe_pkg::OP_ADD, pfe_pkg::OP_SUB, pfe_pkg::OP_MUL, pfe_pkg::OP_DIV: begin
                  if (count < CW'(2)) begin
                    err <= pfe_pkg::ST_UNDERFLOW;
                  end else begin
                    state <= S_READ;
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end
        S_READ: begin
          unique case (cur_op)
            pfe_pkg::OP_ADD: begin
              top   <= rd_data + top;
              count <= count_m1;
              state <= after;
            end
            pfe_pkg::OP_SUB: begin
              top   <= rd_data - top;
              count <= count_m1;
              state <= after;
            end
            pfe_pkg::OP_MUL: begin
              top   <= prod;
              count <= count_m1;
              state <= after;
            end
            pfe_pkg::OP_DIV: begin
              if (top == '0) begin
                err   <= pfe_pkg::ST_DIVZERO;
                state <= after;
              end else begin
                state <= S_DIV;
              end
            end
            default: state <= after;
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            top   <= div_q;
            count <= count_m1;
            state <= after;
          end
        end
        S_FINAL: begin
          if (load_out) begin
            out_valid <= 1'b1;
            if (err != pfe_pkg::ST_OK) begin
              result_value <= '0;
              status       <= err;
            end else if (count == '0) begin
              result_value <= '0;
              status       <= pfe_pkg::ST_UNDERFLOW;
            end else begin
              result_value <= top;
              status       <= pfe_pkg::ST_OK;
            end
            count <= '0;
            err   <= pfe_pkg::ST_OK;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside divide state");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    load_out |=> count == '0 && err == pfe_pkg::ST_OK && out_valid)
    else $error("expression end did not clear the stack");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != pfe_pkg::ST_OK) |-> result_value == '0)
    else $error("nonzero result with error status");

endmodule

`default_nettype wire

>>> sv/postfix_expression_evaluator.sv
// ============================================================================
// postfix_expression_evaluator: postfix expression evaluator, top level
// Decoder, command queue and stack engine with an iterative divider.
//
//   channel   direction  handshake        payload
//   input     in         push / full      char_code[7:0], is_last
//   result    out        pop / empty      result_value[31:0], status[1:0]
//
// The decoder takes a character in any cycle that full is low.
// The engine takes a digit in its idle state, + - * through a read state, a
// divide through the read and divide states with the one-bit-per-cycle
// divider, and an expression end through a final state that loads the result.
// The result register holds one result while the next expression proceeds.
// Synchronous reset empties the stack, the queue and the result register.
// ============================================================================
`default_nettype none

module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = 128
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [7:0]   char_code,
  input  wire logic         is_last,
  input  wire logic         push,
  output logic              full,
  output logic [31:0]       result_value,
  output logic [1:0]        status,
  output logic              empty,
  input  wire logic         pop
);

  pfe_pkg::cmd_t f_cmd;
  pfe_pkg::cmd_t b_cmd;
  logic          f_push;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;

  // character decoder
  pfe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .char_code (char_code),
    .is_last   (is_last),
    .push      (push),
    .full      (full),
    .q_push    (f_push),
    .q_cmd     (f_cmd),
    .q_full    (q_full)
  );

  // command queue
  pfe_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (f_push),
    .wr_cmd  (f_cmd),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_cmd  (b_cmd),
    .q_empty (q_empty)
  );

  // stack engine
  pfe_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_cmd        (b_cmd),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .result_value (result_value),
    .status       (status)
  );

endmodule

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking bench for the postfix expression evaluator
// Feeds directed and random postfix expressions one character per request,
// predicts each result from its own copy of the stack and the error state,
// and checks every popped result against the oldest prediction. Sender
// gaps and receiver stalls vary from phase to phase.
// ============================================================================

// one predicted end-of-expression result
typedef struct {
  logic [31:0]       value;
  pfe_pkg::status_t  status;
} rpn_answer_t;

class rpn_scoreboard #(int DEPTH = 128);
  logic [31:0]      value_words [DEPTH];
  int unsigned      word_count;
  pfe_pkg::status_t first_error;
  rpn_answer_t      pending_answers[$];
  int unsigned      fail_count;

  function new();
    word_count  = 0;
    first_error = pfe_pkg::ST_OK;
    fail_count  = 0;
  endfunction

  // only the first error of an expression is kept
  function void raise_error(pfe_pkg::status_t code);
    if (first_error == pfe_pkg::ST_OK) first_error = code;
  endfunction

  function void push_word(logic [31:0] w);
    if (word_count >= DEPTH) begin
      raise_error(pfe_pkg::ST_OVERFLOW);
    end else begin
      value_words[word_count] = w;
      word_count++;
    end
  endfunction

  // evaluate one accepted character request
  function void note_char(logic [7:0] c, logic last);
    logic [31:0] lhs;
    logic [31:0] rhs;
    logic [31:0] mag_l;
    logic [31:0] mag_r;
    logic [31:0] quo;
    logic [31:0] res_w;
    rpn_answer_t ans;
    if (first_error == pfe_pkg::ST_OK) begin
      if (c >= pfe_pkg::CH_0 && c <= pfe_pkg::CH_9) begin
        push_word(32'(c - pfe_pkg::CH_0));
      end else if (c inside {pfe_pkg::CH_PLUS, pfe_pkg::CH_MINUS,
                             pfe_pkg::CH_STAR, pfe_pkg::CH_SLASH}) begin
        if (word_count < 2) begin
          raise_error(pfe_pkg::ST_UNDERFLOW);
        end else begin
          rhs = value_words[word_count - 1];
          lhs = value_words[word_count - 2];
          if (c == pfe_pkg::CH_SLASH && rhs == 32'd0) begin
            raise_error(pfe_pkg::ST_DIVZERO);
          end else begin
            case (c)
              pfe_pkg::CH_PLUS:  res_w = lhs + rhs;
              pfe_pkg::CH_MINUS: res_w = lhs - rhs;
              pfe_pkg::CH_STAR:  res_w = lhs * rhs;
              default: begin
                // divide magnitudes, then fix the sign: truncates toward zero
                mag_l = lhs[31] ? 32'd0 - lhs : lhs;
                mag_r = rhs[31] ? 32'd0 - rhs : rhs;
                quo   = mag_l / mag_r;
                res_w = (lhs[31] ^ rhs[31]) ? 32'd0 - quo : quo;
              end
            endcase
            word_count -= 2;
            push_word(res_w);
          end
        end
      end
    end
    // final character: pop the top, report, start over
    if (last) begin
      ans.value = '0;
      if (first_error == pfe_pkg::ST_OK) begin
        if (word_count == 0) raise_error(pfe_pkg::ST_UNDERFLOW);
        else ans.value = value_words[word_count - 1];
      end
      if (first_error != pfe_pkg::ST_OK) ans.value = '0;
      ans.status = first_error;
      pending_answers.push_back(ans);
      word_count  = 0;
      first_error = pfe_pkg::ST_OK;
    end
  endfunction

  // compare one popped result with the oldest prediction
  function void check_result(logic [31:0] value, logic [1:0] st);
    rpn_answer_t want;
    if (pending_answers.size() == 0) begin
      $display("%0t: result with none pending: value %0d status %0d",
               $time, $signed(value), st);
      fail_count++;
      return;
    end
    want = pending_answers.pop_front();
    if (value !== want.value) begin
      $display("%0t: result_value expected %0d actual %0d",
               $time, $signed(want.value), $signed(value));
      fail_count++;
    end
    if (st !== want.status) begin
      $display("%0t: status expected %0d actual %0d", $time, want.status, st);
      fail_count++;
    end
  endfunction
endclass

module tb;

  localparam int STACK_WORDS  = 128;
  localparam int RANDOM_ITEMS = 1325;
  localparam int STALL_LIMIT  = 5000;
  localparam int SETTLE       = 40;

  logic        clk;
  logic        rst       = 1'b1;
  logic [7:0]  char_code = '0;
  logic        is_last   = 1'b0;
  logic        push      = 1'b0;
  logic        pop       = 1'b0;
  logic        full;
  logic        empty;
  logic [31:0] result_value;
  logic [1:0]  status;

  int unsigned idle_pct    = 0;
  int unsigned stall_pct   = 0;
  int unsigned item_count  = 0;
  int unsigned quiet_count = 0;

  rpn_scoreboard #(STACK_WORDS) rpn_check;

  postfix_expression_evaluator #(
    .STACK_DEPTH(STACK_WORDS)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .char_code   (char_code),
    .is_last     (is_last),
    .push        (push),
    .full        (full),
    .result_value(result_value),
    .status      (status),
    .empty       (empty),
    .pop         (pop)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog on cycles without any accepted request
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) quiet_count <= 0;
    else quiet_count <= quiet_count + 1;
    if (quiet_count == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // send one character request, push stays high into the next one
  task automatic send_char(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    char_code <= c;
    is_last   <= last;
    push      <= 1'b1;
    do @(posedge clk); while (full !== 1'b0);
    rpn_check.note_char(c, last);
    item_count++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(8'(s[i]), i == s.len() - 1);
  endtask

  function automatic logic [7:0] pick_op();
    case ($urandom_range(5))
      0:       return pfe_pkg::CH_PLUS;
      1:       return pfe_pkg::CH_MINUS;
      2, 3:    return pfe_pkg::CH_STAR;
      default: return pfe_pkg::CH_SLASH;
    endcase
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'(pfe_pkg::CH_0 + $urandom_range(9));
  endfunction

  // build and send one random expression
  task automatic send_random_expr();
    logic [7:0] q[$];
    int kind;
    int depth;
    int steps;
    int reps;
    logic [7:0] base;
    kind = $urandom_range(99);
    if (kind < 68) begin
      // well formed with random content and some ignored characters
      depth = 0;
      steps = $urandom_range(1, 20);
      for (int i = 0; i < steps; i++) begin
        if ($urandom_range(7) == 0) q.push_back(8'($urandom_range(8'h3A, 8'hFF)));
        if (depth < 2 || $urandom_range(1) == 0) begin
          q.push_back(pick_digit());
          depth++;
        end else begin
          q.push_back(pick_op());
          depth--;
        end
      end
      while (depth > 1 && $urandom_range(3) != 0) begin
        q.push_back(pick_op());
        depth--;
      end
      if (depth == 0) q.push_back(pick_digit());
    end else if (kind < 80) begin
      // power chain for wide and wrapped values, often divided by -1
      if ($urandom_range(2) == 0) begin
        base = 8'(pfe_pkg::CH_0 + 2);
        reps = 30;
      end else begin
        base = 8'(pfe_pkg::CH_0 + $urandom_range(2, 9));
        reps = $urandom_range(8, 31);
      end
      q.push_back(base);
      for (int i = 0; i < reps; i++) begin
        q.push_back(base);
        q.push_back(pfe_pkg::CH_STAR);
      end
      if ($urandom_range(1) == 0) begin
        q.push_back(8'(pfe_pkg::CH_0));
        q.push_back(8'(pfe_pkg::CH_0 + 1));
        q.push_back(pfe_pkg::CH_MINUS);
        q.push_back(pfe_pkg::CH_SLASH);
      end else if ($urandom_range(1) == 0) begin
        q.push_back(pick_digit());
        q.push_back(pick_op());
      end
    end else if (kind < 82) begin
      // stack filled around its depth
      steps = STACK_WORDS - 1 + $urandom_range(0, 3);
      for (int i = 0; i < steps; i++) q.push_back(pick_digit());
      if ($urandom_range(1) == 0) q.push_back(pick_op());
      if ($urandom_range(1) == 0) q.push_back(pick_digit());
    end else if (kind < 92) begin
      // broken sequences, operators and digits with equal odds
      steps = $urandom_range(1, 10);
      for (int i = 0; i < steps; i++)
        q.push_back($urandom_range(1) ? pick_op() : pick_digit());
    end else begin
      // raw bytes
      steps = $urandom_range(1, 6);
      for (int i = 0; i < steps; i++) q.push_back(8'($urandom_range(255)));
    end
    foreach (q[i]) send_char(q[i], i == q.size() - 1);
  endtask

  // result side, pop set once per cycle
  task automatic drain_results();
    forever begin
      pop <= ($urandom_range(99) >= stall_pct);
      @(posedge clk);
      if (pop && empty === 1'b0) rpn_check.check_result(result_value, status);
    end
  endtask

  // main sequence
  initial begin
    int unsigned phase;
    int unsigned start_count;
    rpn_check = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    fork
      drain_results();
    join_none

    // directed expressions
    send_text("7");
    send_text("34+");
    send_text("35-");
    send_text("99*");
    send_text("07-2/");
    send_text("50/");
    send_text("+");
    send_text(" ");
    send_text("12");
    send_text("3 ");
    send_text("+5");

    // random expressions across idle and stall phases
    start_count = item_count;
    while (item_count - start_count < RANDOM_ITEMS) begin
      phase = (item_count - start_count) * 4 / RANDOM_ITEMS;
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 67; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      send_random_expr();
    end
    push <= 1'b0;

    // drain and settle
    while (rpn_check.pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (rpn_check.fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
